// ===== rtl/hash_set_engine_macros.svh =====
// Assertion macros shared by the hash set engine RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef HASH_SET_ENGINE_MACROS_SVH
`define HASH_SET_ENGINE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hse_pkg.sv =====
// Shared types and constants for the hash set engine.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package hse_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned MODE_W = 2;

  localparam int unsigned DEF_BUCKETS = 256;
  localparam int unsigned DEF_WAYS    = 4;

  // Multiplicative hash constant (Knuth)
  localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

  // Operation codes; any other code behaves as a lookup
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture a new transaction and its hash product
    logic rd;     // read the bucket row
    logic done;   // write back and load the result register
    logic clr;    // clear one valid row
  } hse_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
  } hse_sts_t;

endpackage

// ===== rtl/hash_set_engine.sv =====
// Hash set engine: insert, lookup and delete of 32-bit keys in a bucketed table.
// Flow: an accepted transaction reads its bucket row in ST_ADDR; ST_CMP compares,
// writes the row back and loads the result register, holding while an earlier
// result is not yet taken. ST_CMP can accept a new transaction as the last finishes.
// Reset: a clearing pass zeroes every valid row, bucket by bucket, in_ready low.
`timescale 1ns / 1ps

module hash_set_engine #(
  parameter int unsigned BUCKETS = hse_pkg::DEF_BUCKETS,
  parameter int unsigned WAYS    = hse_pkg::DEF_WAYS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hse_pkg::MODE_W-1:0]       in_mode,
  input  logic signed [hse_pkg::KEY_W-1:0] in_key,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_was_present,
  output logic                             out_status
);
  import hse_pkg::*;

  hse_cmd_t cmd;
  hse_sts_t sts;

  hse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hse_datapath #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .out_was_present (out_was_present),
    .out_status      (out_status)
  );

endmodule

// ===== rtl/hse_ctrl.sv =====
// Controller for the hash set engine: state machine and result valid flag.
// Depends on hse_pkg and hash_set_engine_macros.svh.
`timescale 1ns / 1ps
`include "hash_set_engine_macros.svh"

module hse_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hse_pkg::hse_sts_t sts,
  output hse_pkg::hse_cmd_t cmd
);
  import hse_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_CMP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) || ((state_r == ST_CMP) && out_free);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd      = '0;
    cmd.load = accept;
    cmd.rd   = (state_r == ST_ADDR);
    cmd.done = (state_r == ST_CMP) && out_free;
    cmd.clr  = (state_r == ST_CLEAR);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // hold until the result register can take the result
        if (out_free) begin
          state_nxt = accept ? ST_ADDR : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `HSE_ASSERT_IMP(a_no_accept_in_clear, state_r == ST_CLEAR, !in_ready, "accept during clear")
  `HSE_ASSERT_NXT(a_addr_then_cmp, state_r == ST_ADDR, state_r == ST_CMP, "read without compare")
  `HSE_ASSERT_NXT(a_done_sets_valid, cmd.done, out_valid_r, "result lost after write back")
  `HSE_ASSERT_IMP(a_done_slot_free, cmd.done && out_valid_r, out_ready, "pending result lost")

endmodule

// ===== rtl/hse_datapath.sv =====
// Datapath for the hash set engine: hash, bucket memories, way compare, result register.
// Depends on hse_pkg; driven by hse_ctrl commands.
`timescale 1ns / 1ps

module hse_datapath #(
  parameter int unsigned BUCKETS = hse_pkg::DEF_BUCKETS,
  parameter int unsigned WAYS    = hse_pkg::DEF_WAYS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hse_pkg::hse_cmd_t                cmd,
  output hse_pkg::hse_sts_t                sts,
  input  logic [hse_pkg::MODE_W-1:0]       in_mode,
  input  logic signed [hse_pkg::KEY_W-1:0] in_key,
  output logic                             out_was_present,
  output logic                             out_status
);
  import hse_pkg::*;

  localparam int unsigned BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned ROW_W = WAYS * KEY_W;
  localparam logic [BKT_W-1:0] HASH_MASK = (BUCKETS > 1) ? {BKT_W{1'b1}} : '0;
  localparam logic [BKT_W:0]   BKT_LIM   = (BKT_W + 1)'(BUCKETS);
  localparam logic [BKT_W-1:0] BKT_LAST  = BKT_W'(BUCKETS - 1);

  // One row per bucket: all ways side by side
  logic [ROW_W-1:0] key_mem [BUCKETS];
  logic [WAYS-1:0]  vld_mem [BUCKETS];

  logic [KEY_W-1:0]  key_r;
  logic [MODE_W-1:0] mode_r;
  logic [KEY_W-1:0]  prod_r;
  logic [KEY_W-1:0]  prod;
  logic [BKT_W-1:0]  bkt_r;
  logic [ROW_W-1:0]  rd_keys_r;
  logic [WAYS-1:0]   rd_vld_r;
  logic [BKT_W-1:0]  clr_cnt_r;
  logic              out_was_present_r;
  logic              out_status_r;

  logic [BKT_W:0]    hbits;
  logic [BKT_W-1:0]  bkt;
  logic [WAYS-1:0]   hit_vec, free_vec, hit_oh, free_oh;
  logic              present, has_free, is_insert, is_delete, ins_ok;
  logic [ROW_W-1:0]  key_row_nxt;
  logic              key_we, vld_we;
  logic [WAYS-1:0]   vld_wdata;
  logic [BKT_W-1:0]  vld_waddr;

  assign prod = $unsigned(in_key) * HASH_MULT;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= $unsigned(in_key);
      mode_r <= in_mode;
      prod_r <= prod;
    end
  end

  // Fold the masked hash into range once for non power-of-two bucket counts
  assign hbits = {1'b0, prod_r[BKT_W-1:0] & HASH_MASK};
  assign bkt   = (hbits >= BKT_LIM) ? BKT_W'(hbits - BKT_LIM) : hbits[BKT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      bkt_r     <= bkt;
      rd_keys_r <= key_mem[bkt];
      rd_vld_r  <= vld_mem[bkt];
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = rd_vld_r[w] && (rd_keys_r[w*KEY_W +: KEY_W] == key_r);
      free_vec[w] = !rd_vld_r[w];
    end
  end

  // Lowest set bit picks the first matching and the first free way
  assign hit_oh    = hit_vec & (~hit_vec + WAYS'(1));
  assign free_oh   = free_vec & (~free_vec + WAYS'(1));
  assign present   = |hit_vec;
  assign has_free  = |free_vec;
  assign is_insert = (mode_r == MODE_INSERT);
  assign is_delete = (mode_r == MODE_DELETE);
  assign ins_ok    = is_insert && !present && has_free;

  always_comb begin
    key_row_nxt = rd_keys_r;
    for (int w = 0; w < WAYS; w++) begin
      if (free_oh[w]) begin
        key_row_nxt[w*KEY_W +: KEY_W] = key_r;
      end
    end
  end

  assign key_we    = cmd.done && ins_ok;
  assign vld_we    = cmd.clr || (cmd.done && (ins_ok || (is_delete && present)));
  assign vld_waddr = cmd.clr ? clr_cnt_r : bkt_r;
  assign vld_wdata = cmd.clr ? '0 : (ins_ok ? (rd_vld_r | free_oh) : (rd_vld_r & ~hit_oh));

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[bkt_r] <= key_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[vld_waddr] <= vld_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + BKT_W'(1);
    end
  end

  assign sts.clr_last = (clr_cnt_r == BKT_LAST);

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      out_was_present_r <= present;
      out_status_r      <= (is_insert && !present && !has_free) ? STATUS_FULL : STATUS_DONE;
    end
  end

  assign out_was_present = out_was_present_r;
  assign out_status      = out_status_r;

endmodule
